// ===== hw/rtl/tsa_pkg.sv =====
// ----------------------------------------------------------------------------
// tsa_pkg: shared types and codes for talk slot admission
// Item formats, list entry format, cell commands and status/operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tsa_pkg;

    localparam int ID_BITS          = 10;
    localparam int CNT_BITS         = 5;
    localparam int CFG_BITS         = 5;
    localparam int SLOT_COUNT_DEF   = 16;
    localparam int CHAIR_LIMIT_DEF  = 8;

    localparam logic [CFG_BITS-1:0] MAX_TALKERS_RST = CFG_BITS'(4);

    // operation codes
    localparam logic [1:0] OP_TALK  = 2'd0;
    localparam logic [1:0] OP_ALIVE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OPENED   = 3'd0;
    localparam logic [2:0] ST_SAME     = 3'd1;
    localparam logic [2:0] ST_CLOSED   = 3'd2;
    localparam logic [2:0] ST_REJECTED = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    // configuration register indexes
    localparam logic CFG_MAX_TALKERS = 1'b0;
    localparam logic CFG_FIFO_MODE   = 1'b1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [ID_BITS-1:0] device_id;
        logic               is_chair;
        logic               flag;
    } tsa_in_t;

    typedef struct packed {
        logic [2:0]          status;
        logic                kicked_valid;
        logic [ID_BITS-1:0]  kicked_id;
        logic [CNT_BITS-1:0] open_count;
    } tsa_out_t;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic               chair;
        logic               alive;
    } tsa_entry_t;

    // command broadcast to every cell of the ring
    typedef struct packed {
        logic rotate;
        logic remove;
        logic append;
        logic set_alive;
        logic alive_val;
    } tsa_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tsa_cell.sv =====
// ----------------------------------------------------------------------------
// tsa_cell: one slot of the talker ring
// Holds one list entry; rotates, compacts from its neighbor, appends or
// updates its alive mark by comparing its own position with broadcast slots.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_cell
    import tsa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int IDX        = 0
) (
    input  wire logic                          aclk,
    input  wire tsa_cmd_t                      cmd,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] rm_pos,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] app_pos,
    input  wire tsa_entry_t                    new_entry,
    input  wire tsa_entry_t                    nbr_entry,
    output tsa_entry_t                         entry
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam logic [IW-1:0] MY_POS = IW'(IDX);

    tsa_entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (cmd.rotate) begin
            entry_reg <= nbr_entry;
        end else if (cmd.append && MY_POS == app_pos) begin
            entry_reg <= new_entry;
        end else if (cmd.remove && MY_POS >= rm_pos) begin
            // close the gap: everything behind the removed slot moves up
            entry_reg <= nbr_entry;
        end else if (cmd.set_alive && MY_POS == rm_pos) begin
            entry_reg.alive <= cmd.alive_val;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsa_ctrl: walk sequencer and admission decision
// Watches the ring head during a full rotation (talk and liveness items only),
// then decides the item and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_ctrl
    import tsa_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int CHAIR_LIMIT = CHAIR_LIMIT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire tsa_in_t                       s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output tsa_out_t                           m_data,
    input  wire logic [CFG_BITS-1:0]           max_talkers,
    input  wire logic                          fifo_mode,
    input  wire tsa_entry_t                    head,
    output tsa_cmd_t                           cmd,
    output logic [$clog2(SLOT_COUNT)-1:0]      rm_pos,
    output logic [$clog2(SLOT_COUNT)-1:0]      app_pos,
    output tsa_entry_t                         new_entry
);

    localparam int IW   = $clog2(SLOT_COUNT);
    localparam int CW   = $clog2(SLOT_COUNT + 1);
    localparam int MW   = (CW > CFG_BITS) ? CW : CFG_BITS;
    localparam int XW   = CW + CNT_BITS;
    localparam logic [IW-1:0] LAST_POS = IW'(SLOT_COUNT - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_WALK   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_SPARE  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    tsa_in_t            item_reg;
    logic [IW-1:0]      k_reg, k_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               found_reg, found_next;
    logic [IW-1:0]      pos_reg, pos_next;
    logic               vdone_reg, vdone_next;
    logic               wadmit_reg, wadmit_next;
    logic               vic_vld_reg, vic_vld_next;
    logic [IW-1:0]      vic_pos_reg, vic_pos_next;
    logic               vic_alive_reg, vic_alive_next;
    logic [ID_BITS-1:0] vic_id_reg, vic_id_next;
    logic [CW-1:0]      opened_reg, opened_next;
    logic               m_valid_reg;
    tsa_out_t           m_data_reg;

    logic               accept;
    logic               go;
    logic               in_list;
    logic [CW-1:0]      opened_dec;
    logic               early;
    logic               kick;
    logic [CW-1:0]      cnt_k;
    logic [CW-1:0]      count_dec;
    logic [XW-1:0]      cnt_wide;
    tsa_out_t           res;
    tsa_cmd_t           dcmd;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign go      = (state_reg == S_DECIDE) && (!m_valid_reg || m_ready);
    assign in_list = (CW'(k_reg) < count_reg);
    assign opened_dec = opened_reg - CW'(1);

    // walk over the ring head, one entry per cycle
    always_comb begin
        k_next         = k_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        vdone_next     = vdone_reg;
        wadmit_next    = wadmit_reg;
        vic_vld_next   = vic_vld_reg;
        vic_pos_next   = vic_pos_reg;
        vic_alive_next = vic_alive_reg;
        vic_id_next    = vic_id_reg;
        opened_next    = opened_reg;
        state_next     = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    k_next       = '0;
                    found_next   = 1'b0;
                    vdone_next   = 1'b0;
                    wadmit_next  = 1'b0;
                    vic_vld_next = 1'b0;
                    opened_next  = count_reg;
                    if (s_data.operation == OP_TALK || s_data.operation == OP_ALIVE) begin
                        state_next = S_WALK;
                    end else begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_WALK: begin
                if (in_list) begin
                    if (!found_reg && head.id == item_reg.device_id) begin
                        found_next = 1'b1;
                        pos_next   = k_reg;
                    end
                    if (!vdone_reg) begin
                        if (head.chair) begin
                            opened_next = opened_dec;
                            if (MW'(opened_dec) < MW'(max_talkers)) begin
                                wadmit_next = 1'b1;
                                vdone_next  = 1'b1;
                            end
                        end else if (!head.alive) begin
                            // first dead talker wins outright
                            vic_vld_next   = 1'b1;
                            vic_pos_next   = k_reg;
                            vic_alive_next = 1'b0;
                            vic_id_next    = head.id;
                            vdone_next     = 1'b1;
                        end else if (!vic_vld_reg) begin
                            vic_vld_next   = 1'b1;
                            vic_pos_next   = k_reg;
                            vic_alive_next = 1'b1;
                            vic_id_next    = head.id;
                        end
                    end
                end
                if (k_reg == LAST_POS) begin
                    state_next = S_DECIDE;
                end else begin
                    k_next = k_reg + IW'(1);
                end
            end
            S_DECIDE: begin
                if (go) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // admission decision
    always_comb begin
        early = (item_reg.is_chair && (32'(count_reg) < 32'(CHAIR_LIMIT)))
                || (MW'(count_reg) < MW'(max_talkers)) || wadmit_reg;
        kick  = 1'b0;
        cnt_k = count_reg;
        count_dec = count_reg - CW'(1);
        count_next = count_reg;
        dcmd = '0;
        rm_pos = pos_reg;
        res = '0;
        res.status = ST_DONE;
        case (item_reg.operation)
            OP_TALK: begin
                if (!item_reg.flag) begin
                    if (found_reg) begin
                        dcmd.remove = 1'b1;
                        count_next  = count_dec;
                        res.status  = ST_CLOSED;
                    end else begin
                        res.status = ST_SAME;
                    end
                end else if (found_reg) begin
                    res.status = ST_SAME;
                end else begin
                    kick  = !early && vic_vld_reg && (!vic_alive_reg || fifo_mode);
                    cnt_k = kick ? count_dec : count_reg;
                    if ((early || kick) && cnt_k < CW'(SLOT_COUNT)) begin
                        dcmd.remove      = kick;
                        dcmd.append      = 1'b1;
                        rm_pos           = vic_pos_reg;
                        count_next       = cnt_k + CW'(1);
                        res.status       = ST_OPENED;
                        res.kicked_valid = kick;
                        res.kicked_id    = kick ? vic_id_reg : '0;
                    end else begin
                        res.status = ST_REJECTED;
                    end
                end
            end
            OP_ALIVE: begin
                dcmd.set_alive = found_reg;
                dcmd.alive_val = item_reg.flag;
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
                res.status = ST_REJECTED;
            end
        endcase
        cnt_wide = XW'(count_next);
        res.open_count = cnt_wide[CNT_BITS-1:0];
    end

    always_comb begin
        cmd = '0;
        if (state_reg == S_WALK) begin
            cmd.rotate = 1'b1;
        end else if (go) begin
            cmd = dcmd;
        end
    end

    assign app_pos         = cnt_k[IW-1:0];
    assign new_entry.id    = item_reg.device_id;
    assign new_entry.chair = item_reg.is_chair;
    assign new_entry.alive = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (go) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        if (go) begin
            m_data_reg <= res;
        end
        k_reg         <= k_next;
        found_reg     <= found_next;
        pos_reg       <= pos_next;
        vdone_reg     <= vdone_next;
        wadmit_reg    <= wadmit_next;
        vic_vld_reg   <= vic_vld_next;
        vic_pos_reg   <= vic_pos_next;
        vic_alive_reg <= vic_alive_next;
        vic_id_reg    <= vic_id_next;
        opened_reg    <= opened_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_kick_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.kicked_valid) |-> (m_data_reg.status == ST_OPENED))
        else $error("kick reported without an open");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !go |=> $stable(count_reg))
        else $error("talker count moved outside a decision");

    a_walk_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK && k_reg == LAST_POS) |=> (state_reg == S_DECIDE))
        else $error("walk did not end after a full rotation");

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        go |=> (32'(count_reg) <= 32'(SLOT_COUNT)))
        else $error("talker count beyond storage");

endmodule

`default_nettype wire

// ===== hw/rtl/talk_slot_admission.sv =====
// Flow: for a talk request or liveness report the ring of slot cells turns
//   fully, one entry past the head per cycle, then the item is decided; a clear
//   or unused operation goes straight to the decision. The result is registered.
//   A new item is taken only after the last one is decided, and a decision
//   waits while an earlier result is still held untaken in the output register.
// Reset (aresetn low, synchronous): list emptied, max_talkers 4, fifo_mode 0;
//   slot contents are not cleared.
// ----------------------------------------------------------------------------
// talk_slot_admission: microphone floor control
// Ordered talker list held in a ring of cells, with open/close, kick,
// liveness and clear handling.
// ----------------------------------------------------------------------------
`default_nettype none

module talk_slot_admission
    import tsa_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int CHAIR_LIMIT = CHAIR_LIMIT_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire tsa_in_t             s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tsa_out_t                 m_data,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [CFG_BITS-1:0] cfg_wdata
);

    localparam int IW = $clog2(SLOT_COUNT);

    logic [CFG_BITS-1:0] max_talkers_reg;
    logic                fifo_mode_reg;
    tsa_cmd_t            cmd;
    logic [IW-1:0]       rm_pos;
    logic [IW-1:0]       app_pos;
    tsa_entry_t          new_entry;
    tsa_entry_t          ring [SLOT_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_talkers_reg <= MAX_TALKERS_RST;
            fifo_mode_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAX_TALKERS: max_talkers_reg <= cfg_wdata;
                CFG_FIFO_MODE:   fifo_mode_reg   <= cfg_wdata[0];
                default:         fifo_mode_reg   <= fifo_mode_reg;
            endcase
        end
    end

    // slot 0 is the head; each cell takes its successor's entry, the last
    // one wraps to the head
    for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
        tsa_cell #(
            .SLOT_COUNT (SLOT_COUNT),
            .IDX        (i)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .rm_pos    (rm_pos),
            .app_pos   (app_pos),
            .new_entry (new_entry),
            .nbr_entry (ring[(i + 1) % SLOT_COUNT]),
            .entry     (ring[i])
        );
    end

    tsa_ctrl #(
        .SLOT_COUNT  (SLOT_COUNT),
        .CHAIR_LIMIT (CHAIR_LIMIT)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .max_talkers (max_talkers_reg),
        .fifo_mode   (fifo_mode_reg),
        .head        (ring[0]),
        .cmd         (cmd),
        .rm_pos      (rm_pos),
        .app_pos     (app_pos),
        .new_entry   (new_entry)
    );

endmodule

`default_nettype wire

// ===== sim/talk_slot_admission_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// talk_slot_admission_test: self-checking bench for microphone floor control
// Drives talk, liveness, clear and unused items through the valid/ready input,
// predicts every result from a local copy of the talker list and checks it
// against the output channel in order, under random idling on both sides.
// ----------------------------------------------------------------------------

module talk_slot_admission_test;
    import tsa_pkg::*;

    localparam int SLOTS       = SLOT_COUNT_DEF;
    localparam int CHAIRS      = CHAIR_LIMIT_DEF;
    localparam int POOL        = 20;
    localparam int PHASE_ITEMS = 100;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 2 * SLOTS + 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    tsa_in_t             s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    tsa_out_t            m_data;
    logic                cfg_we    = 1'b0;
    logic                cfg_index = 1'b0;
    logic [CFG_BITS-1:0] cfg_wdata = '0;

    // bench control, driven from the sequencer
    logic calm          = 1'b0;
    logic long_hold_req = 1'b0;

    // local copy of the talker list and of the registers
    logic [ID_BITS-1:0]  list_id    [SLOTS];
    logic                list_chair [SLOTS];
    logic                list_alive [SLOTS];
    int                  list_count      = 0;
    logic [CFG_BITS-1:0] cur_max_talkers = MAX_TALKERS_RST;
    logic                cur_fifo_mode   = 1'b0;

    tsa_in_t            talk_items  [$];
    tsa_out_t           floor_expect[$];
    logic [ID_BITS-1:0] id_pool     [POOL];

    int fail_count  = 0;
    int result_num  = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    bit hold_done   = 1'b0;
    int cycle_count = 0;

    always #4 aclk = ~aclk;

    talk_slot_admission #(
        .SLOT_COUNT  (SLOTS),
        .CHAIR_LIMIT (CHAIRS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    task automatic drop_entry(input int pos);
        int i;
        for (i = pos; i + 1 < list_count; i++) begin
            list_id[i]    = list_id[i + 1];
            list_chair[i] = list_chair[i + 1];
            list_alive[i] = list_alive[i + 1];
        end
        list_count--;
    endtask

    // floor decision for one item; updates the local list
    task automatic floor_decision(input tsa_in_t req, output tsa_out_t res);
        int  i;
        int  pos;
        int  opened;
        int  victim;
        bit  admit;
        res        = '0;
        res.status = ST_DONE;
        pos        = -1;
        for (i = 0; i < list_count; i++)
            if (list_id[i] == req.device_id) pos = i;
        case (req.operation)
            OP_TALK: begin
                if (!req.flag) begin
                    if (pos < 0) begin
                        res.status = ST_SAME;
                    end else begin
                        drop_entry(pos);
                        res.status = ST_CLOSED;
                    end
                end else if (pos >= 0) begin
                    res.status = ST_SAME;
                end else begin
                    admit  = 1'b0;
                    victim = -1;
                    if (req.is_chair && list_count < CHAIRS) begin
                        admit = 1'b1;
                    end else if (list_count < int'(cur_max_talkers)) begin
                        admit = 1'b1;
                    end else begin
                        // walk oldest first: chairs do not count against the limit,
                        // first dead non-chair is the victim, else the oldest live one
                        opened = list_count;
                        for (i = 0; i < list_count; i++) begin
                            if (list_chair[i]) begin
                                opened--;
                                if (opened < int'(cur_max_talkers)) begin
                                    admit = 1'b1;
                                    break;
                                end
                            end else if (!list_alive[i]) begin
                                victim = i;
                                break;
                            end else if (victim < 0) begin
                                victim = i;
                            end
                        end
                        if (!admit && victim >= 0 &&
                            (!list_alive[victim] || cur_fifo_mode)) begin
                            res.kicked_valid = 1'b1;
                            res.kicked_id    = list_id[victim];
                            drop_entry(victim);
                            admit = 1'b1;
                        end
                    end
                    if (admit && list_count < SLOTS) begin
                        list_id[list_count]    = req.device_id;
                        list_chair[list_count] = req.is_chair;
                        list_alive[list_count] = 1'b1;
                        list_count++;
                        res.status = ST_OPENED;
                    end else begin
                        res.status = ST_REJECTED;
                    end
                end
            end
            OP_ALIVE: begin
                if (pos >= 0) list_alive[pos] = req.flag;
            end
            OP_CLEAR: begin
                list_count = 0;
            end
            default: begin
                res.status = ST_REJECTED;
            end
        endcase
        res.open_count = CNT_BITS'(list_count);
    endtask

    // sender
    always @(posedge aclk) begin
        tsa_out_t res;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                floor_decision(s_data, res);
                floor_expect.push_back(res);
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (talk_items.size() != 0 && !calm &&
                             $urandom_range(0, 9) == 0) begin
                    gap_left <= $urandom_range(0, 6);
                    s_valid  <= 1'b0;
                end else if (talk_items.size() != 0) begin
                    s_data  <= talk_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (long_hold_req && !hold_done) begin
            hold_done  <= 1'b1;
            stall_left <= LONG_HOLD;
            m_ready    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        tsa_out_t want;
        bit       bad;
        if (aresetn && m_valid && m_ready) begin
            if (floor_expect.size() == 0) begin
                if (fail_count < 10)
                    $display("%0t: unexpected result status %0d count %0d", $realtime,
                             m_data.status, m_data.open_count);
                fail_count++;
            end else begin
                want = floor_expect.pop_front();
                bad  = (m_data.status !== want.status) ||
                       (m_data.kicked_valid !== want.kicked_valid) ||
                       (m_data.kicked_id !== want.kicked_id) ||
                       (m_data.open_count !== want.open_count);
                if (bad) begin
                    if (fail_count < 10)
                        $display({"%0t: result %0d mismatch: expected st %0d kick %0b/%0d ",
                                  "cnt %0d, got st %0d kick %0b/%0d cnt %0d"},
                                 $realtime, result_num, want.status, want.kicked_valid,
                                 want.kicked_id, want.open_count, m_data.status,
                                 m_data.kicked_valid, m_data.kicked_id, m_data.open_count);
                    fail_count++;
                end
            end
            result_num++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic offer(input logic [1:0] op, input logic [ID_BITS-1:0] id,
                         input logic chair, input logic flag);
        tsa_in_t it;
        it.operation = op;
        it.device_id = id;
        it.is_chair  = chair;
        it.flag      = flag;
        talk_items.push_back(it);
    endtask

    // sender paused until every result is back, plus the block's latency
    task automatic wait_drained();
        @(negedge aclk);
        while (talk_items.size() != 0 || s_valid || floor_expect.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_BITS-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_TALKERS) cur_max_talkers = val;
        else cur_fifo_mode = val[0];
    endtask

    function automatic tsa_in_t random_item();
        tsa_in_t it;
        int      pick;
        if ($urandom_range(0, 99) < 85) it.device_id = id_pool[$urandom_range(0, POOL - 1)];
        else it.device_id = ID_BITS'($urandom);
        it.is_chair = ($urandom_range(0, 3) == 0);
        it.flag     = 1'($urandom_range(0, 1));
        pick        = $urandom_range(0, 99);
        if (pick < 48) begin
            it.operation = OP_TALK;
            it.flag      = 1'b1;
        end else if (pick < 68) begin
            it.operation = OP_TALK;
            it.flag      = 1'b0;
        end else if (pick < 95) begin
            it.operation = OP_ALIVE;
        end else if (pick < 98) begin
            it.operation = OP_CLEAR;
        end else begin
            it.operation = OP_UNUSED;
        end
        return it;
    endfunction

    initial begin
        int max_set  [8];
        bit fifo_set [8];
        int p;
        int n;
        max_set  = '{0, 16, 1, 4, 16, 2, 8, 3};
        fifo_set = '{1, 1, 0, 1, 0, 1, 0, 0};
        max_set[6]  = $urandom_range(0, 16);
        fifo_set[6] = 1'($urandom_range(0, 1));
        foreach (id_pool[k]) id_pool[k] = ID_BITS'($urandom);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: limit 4, no FIFO kick
        offer(OP_TALK,   10'd0,     1'b0, 1'b1);  // first open
        offer(OP_TALK,   10'd1023,  1'b1, 1'b1);  // chair
        offer(OP_TALK,   10'd0,     1'b0, 1'b1);  // already open
        offer(OP_TALK,   10'd5,     1'b0, 1'b0);  // already closed
        offer(OP_ALIVE,  10'd7,     1'b0, 1'b1);  // unknown device
        offer(OP_UNUSED, 10'd1023,  1'b1, 1'b1);
        offer(OP_TALK,   10'h155,   1'b0, 1'b1);
        offer(OP_TALK,   10'h2aa,   1'b0, 1'b1);
        offer(OP_ALIVE,  10'd0,     1'b0, 1'b0);  // oldest goes dead
        offer(OP_TALK,   10'h0f0,   1'b0, 1'b1);  // kicks the dead one
        offer(OP_TALK,   10'h30f,   1'b0, 1'b1);  // chair lowers count
        offer(OP_TALK,   10'd1023,  1'b1, 1'b0);  // close
        offer(OP_CLEAR,  10'd0,     1'b0, 1'b0);
        wait_drained();

        // fill the list to the storage limit
        write_reg(CFG_MAX_TALKERS, 5'd16);
        write_reg(CFG_FIFO_MODE, CFG_BITS'(1'b0));
        offer(OP_TALK, 10'd100, 1'b1, 1'b1);
        for (n = 0; n < SLOTS - 1; n++)
            offer(OP_TALK, ID_BITS'(200 + n), 1'b0, 1'b1);
        offer(OP_TALK, 10'd300, 1'b0, 1'b1);  // admitted by the walk, but no room
        offer(OP_CLEAR, 10'd0, 1'b0, 1'b0);
        wait_drained();

        for (p = 0; p < 8; p++) begin
            write_reg(CFG_MAX_TALKERS, CFG_BITS'(max_set[p]));
            write_reg(CFG_FIFO_MODE, CFG_BITS'(fifo_set[p]));
            if (p == 7) begin
                @(posedge aclk);
                calm <= 1'b1;
            end
            for (n = 0; n < PHASE_ITEMS; n++) talk_items.push_back(random_item());
            if (p == 1) begin
                @(posedge aclk);
                long_hold_req <= 1'b1;
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
